[src/fps_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the Fenwick prefix-sum table.
// Depends on nothing; the interfaces, the engine, the top level and the testbench import it.
package fps_pkg;

  localparam int FPS_ACT_W     = 2;
  localparam int FPS_POS_W     = 11;
  localparam int FPS_DELTA_W   = 32;
  localparam int FPS_DEPTH     = 1024;
  localparam int FPS_SUM_WIDTH = 48;

  typedef logic [FPS_ACT_W-1:0] action_t;
  typedef logic [FPS_POS_W-1:0] pos_t;

  localparam action_t ACT_ADD   = 2'd0;
  localparam action_t ACT_QUERY = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam pos_t SIZE_RESET = 11'd1024;

  // Status from the walk engine to the top level.
  typedef struct packed {
    logic res_valid;
    logic clearing;
  } eng_status_t;

endpackage

[src/fps_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the Fenwick prefix-sum table: command in, result out.
// Depends on fps_pkg.
interface fps_cmd_if import fps_pkg::*;;
  logic                   valid;
  logic                   ready;
  action_t                action;
  pos_t                   position;
  logic signed [FPS_DELTA_W-1:0] delta;

  modport source (output valid, action, position, delta, input ready);
  modport sink   (input valid, action, position, delta, output ready);
endinterface

interface fps_res_if import fps_pkg::*; #(
  parameter int SUM_WIDTH = FPS_SUM_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic signed [SUM_WIDTH-1:0] prefix_sum;

  modport source (output valid, prefix_sum, input ready);
  modport sink   (input valid, prefix_sum, output ready);
endinterface

[src/fps_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module fps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/fps_engine.sv]
`timescale 1ns / 1ps
// Walk engine: takes commands, runs the clearing sweep and the update/query walks
// over the partial-sum RAM. Depends on fps_pkg and fps_if.
module fps_engine import fps_pkg::*; #(
  parameter int DEPTH     = FPS_DEPTH,
  parameter int SUM_WIDTH = FPS_SUM_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  fps_cmd_if.sink                  cmd,
  input  pos_t                     size_in_use,
  input  logic                     res_free,
  output eng_status_t              status,
  output logic [SUM_WIDTH-1:0]     sum,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [SUM_WIDTH-1:0]     wr_data,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [SUM_WIDTH-1:0]     rd_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int WALK_W = FPS_POS_W + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]           state;
  logic [AW-1:0]        clr_addr;
  logic                 clr_reply;
  logic                 pend;
  logic                 is_upd;
  logic [WALK_W-1:0]    walk;
  logic [AW-1:0]        prev_addr;
  logic [SUM_WIDTH-1:0] acc;
  logic [SUM_WIDTH-1:0] delta_r;

  logic [WALK_W-1:0]    lim;
  logic [WALK_W-1:0]    pos_ext;
  logic [WALK_W-1:0]    qstart;
  logic [WALK_W-1:0]    low;
  logic [AW-1:0]        walk_addr;
  logic                 go;
  logic                 clr_last;

  always_comb begin
    if (32'(size_in_use) > DEPTH) begin
      lim = WALK_W'(DEPTH);
    end else begin
      lim = WALK_W'(size_in_use);
    end
    pos_ext   = WALK_W'(cmd.position);
    qstart    = (pos_ext > lim) ? lim : pos_ext;
    low       = walk & (~walk + WALK_W'(1));
    walk_addr = AW'(walk - WALK_W'(1));
    go        = (walk != '0) && (walk <= lim);
    clr_last  = (clr_addr == AW'(DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_last) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            is_upd  <= (cmd.action == ACT_ADD);
            acc     <= '0;
            delta_r <= SUM_WIDTH'(cmd.delta);
            pend    <= 1'b0;
            unique case (cmd.action)
              ACT_ADD: begin
                walk  <= pos_ext;
                state <= S_WALK;
              end
              ACT_QUERY: begin
                walk  <= qstart;
                state <= S_WALK;
              end
              ACT_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WALK: begin
          if (pend && !is_upd) begin
            acc <= acc + rd_data;
          end
          if (go) begin
            prev_addr <= walk_addr;
            pend      <= 1'b1;
            walk      <= is_upd ? walk + low : walk - low;
          end else begin
            pend <= 1'b0;
            // last write-back or accumulate lands this cycle
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Each walk step touches a fresh entry, and the next command starts only after
  // the final write-back, so reads never meet a pending write to the same entry.
  always_comb begin
    cmd.ready        = (state == S_IDLE);
    status.clearing  = (state == S_CLEAR);
    status.res_valid = (state == S_DONE) && res_free;
    sum              = acc;
    wr_en            = (state == S_CLEAR) || ((state == S_WALK) && pend && is_upd);
    wr_addr          = (state == S_CLEAR) ? clr_addr : prev_addr;
    wr_data          = (state == S_CLEAR) ? '0 : rd_data + delta_r;
    rd_en            = (state == S_WALK) && go;
    rd_addr          = walk_addr;
  end

endmodule

[src/fenwick_prefix_sum_table_top.sv]
`timescale 1ns / 1ps
// Top level of the Fenwick prefix-sum table: size register, walk engine,
// partial-sum RAM and result register. Depends on fps_pkg, fps_if, fps_ram, fps_engine.
//
// Usage:
//   cmd  - valid/ready command channel: action (add, query, clear), position, delta.
//   res  - valid/ready result channel: one prefix_sum per command transaction,
//          the prefix sum for a query and zero for every other action.
//   cfg_we/cfg_wdata - write size_in_use; write only while the block is idle.
// Timing: an add or query visits k partial sums (k at most log2(size)+1), one per
//   cycle through the one RAM read port, and then loads the result register; a
//   clear sweeps every RAM entry; an unused action goes straight to the result.
//   The next command is taken only once the result register is loaded, so one
//   command is in work at a time.
// Reset: rst (synchronous) sets size_in_use to 1024 and starts a clearing pass
//   that zeroes the RAM; cmd.ready stays low until it ends.
// Stall: a finished result waits in the result register, and the engine takes
//   the next command meanwhile; its own result is held back until the register
//   empties or is taken in the same cycle.
module fenwick_prefix_sum_table_top import fps_pkg::*; #(
  parameter int DEPTH     = FPS_DEPTH,
  parameter int SUM_WIDTH = FPS_SUM_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  fps_cmd_if.sink   cmd,
  fps_res_if.source res,
  input  logic      cfg_we,
  input  pos_t      cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  pos_t                 size_in_use;
  logic                 out_valid;
  logic [SUM_WIDTH-1:0] out_sum;
  logic                 res_free;
  eng_status_t          eng_st;
  logic [SUM_WIDTH-1:0] eng_sum;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SUM_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SUM_WIDTH-1:0] rd_data;

  // Hold the configured size; the user must write it only between transactions, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
    end
  end

  // Result register: free when empty or being drained this cycle.
  assign res_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_st.res_valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_st.res_valid) begin
      out_sum <= eng_sum;
    end
  end

  assign res.valid      = out_valid;
  assign res.prefix_sum = out_sum;

  fps_engine #(
    .DEPTH     (DEPTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .size_in_use (size_in_use),
    .res_free    (res_free),
    .status      (eng_st),
    .sum         (eng_sum),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Partial sums, one entry per position.
  fps_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Never take a command during the clearing sweep.
  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (rst)
    eng_st.clearing |-> !cmd.ready)
    else $error("command taken during clearing sweep");

  // Never overwrite a result that is still waiting.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    eng_st.res_valid |-> (!out_valid || res.ready))
    else $error("result register overwritten");

  // Leave reset straight into the clearing sweep.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> eng_st.clearing)
    else $error("no clearing sweep after reset");

endmodule

[tb/fenwick_prefix_sum_table_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Fenwick prefix-sum table: directed and random command
// streams with a cycle-free predictor of the table. Depends on fps_pkg, fps_if and the RTL.
module fenwick_prefix_sum_table_top_test;
  import fps_pkg::*;

  // Action code that the block must treat as a no-op returning zero.
  localparam action_t ACT_SPARE   = 2'd3;
  localparam int      MAX_REPORTS = 10;
  localparam int      IDLE_PCT    = 11;

  typedef logic signed [FPS_SUM_WIDTH-1:0] sum_t;
  typedef logic        [FPS_SUM_WIDTH-1:0] cell_t;
  typedef logic        [FPS_DELTA_W-1:0]   delta_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  pos_t cfg_wdata = '0;

  fps_cmd_if cmd_ch ();
  fps_res_if #(.SUM_WIDTH(FPS_SUM_WIDTH)) res_ch ();

  fenwick_prefix_sum_table_top #(
    .DEPTH    (FPS_DEPTH),
    .SUM_WIDTH(FPS_SUM_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the partial-sum table and the size register.
  // Entry p holds the sum of positions p - lowbit(p) + 1 .. p, wrapping at
  // the sum width.
  // ---------------------------------------------------------------------------
  cell_t fen_cells [1:FPS_DEPTH];
  pos_t  fen_size;
  sum_t  sums_due [$];   // expected prefix sums, oldest first

  function automatic int fen_limit();
    return (fen_size > FPS_DEPTH) ? FPS_DEPTH : int'(fen_size);
  endfunction

  function automatic void fen_clear();
    foreach (fen_cells[i]) fen_cells[i] = '0;
  endfunction

  // Walk upward in lowest-set-bit steps; position zero or beyond the limit
  // touches nothing.
  function automatic void fen_add(pos_t at, delta_t d);
    int    p;
    int    lim;
    cell_t amt;
    amt = {{(FPS_SUM_WIDTH-FPS_DELTA_W){d[FPS_DELTA_W-1]}}, d};
    lim = fen_limit();
    p = int'(at);
    while (p != 0 && p <= lim) begin
      fen_cells[p] = fen_cells[p] + amt;
      p = p + (p & -p);
    end
  endfunction

  // Walk downward from the position, saturated to the limit.
  function automatic sum_t fen_prefix(pos_t upto);
    int    p;
    int    lim;
    cell_t acc;
    lim = fen_limit();
    p = (int'(upto) > lim) ? lim : int'(upto);
    acc = '0;
    while (p != 0) begin
      acc = acc + fen_cells[p];
      p = p - (p & -p);
    end
    return sum_t'(acc);
  endfunction

  function automatic sum_t fen_apply(action_t act, pos_t at, delta_t d);
    sum_t r;
    r = '0;
    case (act)
      ACT_ADD:   fen_add(at, d);
      ACT_QUERY: r = fen_prefix(at);
      ACT_CLEAR: fen_clear();
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Run statistics and failure tallies.
  // ---------------------------------------------------------------------------
  int n_items = 0;
  int n_checked = 0;
  int n_bad = 0;
  int n_adds = 0;
  int n_queries = 0;
  int n_clears = 0;
  int n_sizes = 0;

  // Receiver controls: steady suppresses random idling on both sides,
  // stall_left holds res.ready low for a counted number of cycles.
  bit steady = 1'b0;
  int stall_left = 0;

  // ---------------------------------------------------------------------------
  // Result side: drive ready at the falling edge, idle about 11 percent of
  // the time unless steady, and honour a requested hold-off.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    sum_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sums_due.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("%0t: unexpected result, prefix_sum %0d", $realtime, res_ch.prefix_sum);
      end else begin
        want = sums_due.pop_front();
        n_checked++;
        if (res_ch.prefix_sum !== want) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("%0t: prefix_sum mismatch, expected %0d actual %0d",
                     $realtime, want, res_ch.prefix_sum);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side. send_item offers one transaction at a falling edge, maybe
  // after a short random gap, and returns at the rising edge that accepts it
  // with valid still high, so the next call can follow back to back.
  // ---------------------------------------------------------------------------
  task automatic send_item(action_t act, pos_t at, delta_t d);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 4);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.action   <= act;
    cmd_ch.position <= at;
    cmd_ch.delta    <= d;
    do @(posedge clk); while (!cmd_ch.ready);
    sums_due.insert(sums_due.size(), fen_apply(act, at, d));
    n_items++;
    case (act)
      ACT_ADD:   n_adds++;
      ACT_QUERY: n_queries++;
      ACT_CLEAR: n_clears++;
      default: ;
    endcase
  endtask

  // Drop valid after the last accepted transaction.
  task automatic release_cmd();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
  endtask

  // Release the command channel and wait until every expected result is in.
  task automatic drain_results();
    release_cmd();
    while (sums_due.size() != 0) @(posedge clk);
  endtask

  // Write size_in_use only once the block has gone idle.
  task automatic write_size(pos_t v);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fen_size = v;
    n_sizes++;
  endtask

  // Position: mostly in range, with zero, beyond-size and all-ones cases.
  function automatic pos_t pick_position();
    int lim;
    int r;
    lim = fen_limit();
    r = $urandom_range(99);
    if (lim == 0 || r < 4)  return pos_t'($urandom_range(0, 2047) * (r < 4 ? 0 : 1));
    if (r < 10)             return pos_t'($urandom_range(lim + 1, 2047));
    if (r < 14)             return (r < 12) ? pos_t'(2047) : pos_t'(lim);
    return pos_t'($urandom_range(1, lim));
  endfunction

  function automatic delta_t pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 32'h8000_0000;
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 30) return delta_t'($urandom_range(0, 64)) - delta_t'(32);
    return delta_t'($urandom);
  endfunction

  // Mostly adds and queries so the table builds up before it is read;
  // clears and the spare code are kept rare.
  task automatic send_random_item();
    int      r;
    action_t act;
    r = $urandom_range(999);
    if (r < 12)       act = ACT_CLEAR;
    else if (r < 35)  act = ACT_SPARE;
    else if (r < 480) act = ACT_ADD;
    else              act = ACT_QUERY;
    send_item(act, pick_position(), pick_delta());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Fresh table after reset: every query returns zero.
  task automatic test_reset_state();
    send_item(ACT_QUERY, pos_t'(1024), '0);
    send_item(ACT_QUERY, pos_t'(2047), '0);
    send_item(ACT_QUERY, pos_t'(0), 32'hFFFF_FFFF);
  endtask

  // Field extremes, position zero, updates beyond size, query saturation,
  // the spare code, ignored deltas and clear.
  task automatic test_field_extremes();
    send_item(ACT_ADD,   pos_t'(1),    32'h7FFF_FFFF);
    send_item(ACT_ADD,   pos_t'(1024), 32'h8000_0000);
    send_item(ACT_ADD,   pos_t'(0),    32'd5);
    send_item(ACT_ADD,   pos_t'(2047), 32'd9);
    send_item(ACT_ADD,   pos_t'(1025), 32'd3);
    send_item(ACT_QUERY, pos_t'(1),    '0);
    send_item(ACT_QUERY, pos_t'(1023), '0);
    send_item(ACT_QUERY, pos_t'(1024), '0);
    send_item(ACT_QUERY, pos_t'(2047), '0);
    send_item(ACT_SPARE, pos_t'(5),    32'hFFFF_FFFF);
    send_item(ACT_QUERY, pos_t'(1),    32'd12345);
    send_item(ACT_CLEAR, pos_t'(1024), 32'h7FFF_FFFF);
    send_item(ACT_QUERY, pos_t'(1024), '0);
  endtask

  // Size register: tiny, zero, above depth, and shrinking after updates.
  task automatic test_size_register();
    write_size(pos_t'(3));
    send_item(ACT_ADD,   pos_t'(4),    32'd100);
    send_item(ACT_ADD,   pos_t'(3),    32'hFFFF_FFFE);
    send_item(ACT_QUERY, pos_t'(2047), '0);
    write_size(pos_t'(0));
    send_item(ACT_ADD,   pos_t'(1),    32'd50);
    send_item(ACT_QUERY, pos_t'(3),    '0);
    write_size(pos_t'(2047));
    send_item(ACT_ADD,   pos_t'(1024), 32'd6);
    send_item(ACT_ADD,   pos_t'(1000), 32'd11);
    send_item(ACT_QUERY, pos_t'(2047), '0);
    // Entries above the new size stay put but must not be read.
    write_size(pos_t'(512));
    send_item(ACT_QUERY, pos_t'(1024), '0);
    send_item(ACT_QUERY, pos_t'(512),  '0);
    write_size(pos_t'(1024));
    send_item(ACT_QUERY, pos_t'(1024), '0);
  endtask

  // Hold the result side off for a long stretch while commands keep
  // coming, so the result register and the engine fill and cmd.ready drops.
  task automatic test_back_pressure();
    drain_results();
    stall_left = 400;
    repeat (25) send_random_item();
  endtask

  // Random traffic under a series of sizes; one phase runs with no idling.
  task automatic test_random_phases();
    int sizes [13] = '{1024, 1, 2, 3, 16, 100, 511, 1023, 2047, 1025, 0, 700, 1024};
    foreach (sizes[k]) begin
      write_size(pos_t'(sizes[k]));
      steady = (k == 5);
      repeat (100) send_random_item();
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.action   = ACT_ADD;
    cmd_ch.position = '0;
    cmd_ch.delta    = '0;
    res_ch.ready    = 1'b0;
    fen_clear();
    fen_size = SIZE_RESET;

    // Hold reset, then release it at a falling edge; the block then clears its RAM on its own
    // and keeps cmd.ready low meanwhile.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_size_register();
    test_back_pressure();
    test_random_phases();

    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d transactions (%0d adds, %0d queries, %0d clears) over %0d sizes,",
             n_items, n_adds, n_queries, n_clears, n_sizes);
    $display("checked %0d results, %0d failures, result back-pressure included.",
             n_checked, n_bad);
    if (n_bad == 0 && sums_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
